// File: rtl/ltec_pkg.sv
// Package with shared constants and types for the tagged entry cache.
`default_nettype none
package ltec_pkg;
  localparam int unsigned EntriesDef = 32;
  localparam int unsigned KeyW       = 16;
  localparam int unsigned StampW     = 31;
  localparam int unsigned CountW     = 32;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned HwW        = 6;
  localparam int unsigned ReqW       = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_EVICT  = 2'd2,
    REQ_DIRTY  = 2'd3
  } req_e;

  // entry word: {prefetched, dirty, valid, stamp, key}
  localparam int unsigned EntW = KeyW + StampW + 3;
  typedef struct packed {
    logic              pref;
    logic              dirty;
    logic              valid;
    logic [StampW-1:0] stamp;
    logic [KeyW-1:0]   key;
  } entry_t;
endpackage
`default_nettype wire

// File: rtl/ltec_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module ltec_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/lru_tagged_entry_cache.sv
// Top level of the fully associative LRU tagged entry cache.
// Usage:
//   A request enters on s_axis (tdata = req_type, key, frame, as_prefetch).
//   Exactly one response leaves on m_axis per request carrying hit, slot,
//   flags, the three wrapping counters and the high-water entry count.
//   Entries live in one RAM with registered read; a request's scan walks
//   the RAM one entry per cycle. A scan pass covers the high-water count
//   of entries for the key search, evict and mark-dirty, and ENTRIES for
//   the free-slot and LRU passes. Lookup takes one pass, evict and
//   mark-dirty one pass or none when the high-water count is zero, insert
//   up to four (find key, find free slot, LRU pick, and a second LRU pass
//   when the first pick is prefetched). After reset a clearing pass writes
//   every entry to zero, during which s_axis_tready stays low.
//   One request is in flight at a time. The response is held in an output
//   register; when the receiver stalls the response holds, and the next
//   request is taken only once it has been delivered.
`default_nettype none
module lru_tagged_entry_cache #(
  parameter int unsigned ENTRIES = ltec_pkg::EntriesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // tdata: req_type[1:0], key[17:2], frame[48:18], as_prefetch[49], zeros
  input  wire logic [55:0]  s_axis_tdata,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: hit[0], slot[5:1], slot_valid[6], evicted[7], hit_count[39:8],
  //   miss_count[71:40], evict_count[103:72], entry_count[109:104], zeros
  output      logic [111:0] m_axis_tdata
);
  import ltec_pkg::*;
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIND, S_FREE, S_LRU1, S_LRU2, S_EVSCAN,
    S_DIRTY, S_WRITE, S_OUT
  } state_e;

  state_e state_q;
  logic [ReqW-1:0]   req_q;
  logic [KeyW-1:0]   key_q;
  logic [StampW-1:0] frame_q;
  logic              pf_q;
  logic [CW-1:0]     idx_q;   // read address issued
  logic              rv_q;    // read data valid this cycle
  logic [AW-1:0]     ra_q;    // address of data now on rdata
  logic [CW-1:0]     hw_q;
  logic [CountW-1:0] hits_q, miss_q, evc_q;
  logic              found_q;
  logic [AW-1:0]     pick_q;
  logic [StampW-1:0] old_q;
  entry_t            pick_e_q;
  logic              hit_q, sv_q, ev_q;
  logic [SlotW-1:0]  slot_q;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata, rdata;
  logic [EntW-1:0] rraw;

  ltec_ram #(.Width(EntW), .Depth(ENTRIES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(idx_q[AW-1:0]), .rdata_o(rraw)
  );
  assign rdata = entry_t'(rraw);

  // scan limit of the active pass
  logic [CW-1:0] lim;
  always_comb begin
    lim = CW'(ENTRIES);
    if (state_q == S_FIND || state_q == S_EVSCAN || state_q == S_DIRTY) lim = hw_q;
  end
  logic issue;
  assign issue = idx_q < lim;

  always_comb begin
    we = 1'b0; waddr = ra_q; wdata = rdata;
    if (state_q == S_CLEAR) begin
      we = 1'b1; waddr = idx_q[AW-1:0]; wdata = '0;
    end else if (state_q == S_DIRTY && rv_q) begin
      we = 1'b1; wdata.dirty = 1'b1;
    end else if (state_q == S_WRITE) begin
      we = 1'b1; waddr = pick_q; wdata = pick_e_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {2'b0, HwW'(hw_q), evc_q, miss_q, hits_q,
                         ev_q, sv_q, slot_q, hit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; idx_q <= '0; rv_q <= 1'b0; hw_q <= '0;
      hits_q <= '0; miss_q <= '0; evc_q <= '0;
      hit_q <= 1'b0; sv_q <= 1'b0; ev_q <= 1'b0; slot_q <= '0;
      found_q <= 1'b0; pick_q <= '0;
      req_q <= '0; key_q <= '0; frame_q <= '0; pf_q <= 1'b0;
      ra_q <= '0; old_q <= '0; pick_e_q <= '0;
    end else begin
      rv_q <= 1'b0;
      // stop issuing once the key search or free-slot search has its entry
      if (state_q != S_CLEAR && state_q != S_IDLE && state_q != S_WRITE &&
          state_q != S_OUT && issue &&
          !(found_q && (state_q == S_FIND || state_q == S_FREE))) begin
        idx_q <= idx_q + 1'b1; rv_q <= 1'b1; ra_q <= idx_q[AW-1:0];
      end
      unique case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == CW'(ENTRIES - 1)) begin idx_q <= '0; state_q <= S_IDLE; end
        end
        S_IDLE: if (s_axis_tvalid) begin
          req_q <= s_axis_tdata[1:0]; key_q <= s_axis_tdata[17:2];
          frame_q <= s_axis_tdata[48:18]; pf_q <= s_axis_tdata[49];
          idx_q <= '0; found_q <= 1'b0; pick_q <= '0;
          hit_q <= 1'b0; sv_q <= 1'b0; ev_q <= 1'b0; slot_q <= '0;
          unique case (req_e'(s_axis_tdata[1:0]))
            REQ_LOOKUP, REQ_INSERT: state_q <= S_FIND;
            REQ_EVICT: state_q <= (hw_q == '0) ? S_OUT : S_EVSCAN;
            REQ_DIRTY: state_q <= (hw_q == '0) ? S_OUT : S_DIRTY;
            default: state_q <= S_OUT;
          endcase
        end
        S_FIND: begin
          if (rv_q && !found_q && rdata.valid && rdata.key == key_q) begin
            found_q <= 1'b1; pick_q <= ra_q; pick_e_q <= rdata;
            pick_e_q.stamp <= frame_q;
            if (req_q == REQ_INSERT) pick_e_q.dirty <= 1'b1;
          end
          if (found_q) begin
            hit_q <= 1'b1; sv_q <= 1'b1; slot_q <= SlotW'(pick_q);
            if (req_q == REQ_LOOKUP) hits_q <= hits_q + 1'b1;
            state_q <= S_WRITE;
          end else if (!rv_q && !issue) begin
            if (req_q == REQ_LOOKUP) begin
              miss_q <= miss_q + 1'b1; state_q <= S_OUT;
            end else begin
              idx_q <= '0; state_q <= S_FREE;
            end
          end
        end
        S_FREE: begin
          if (rv_q && !found_q && !rdata.valid) begin
            found_q <= 1'b1; pick_q <= ra_q;
          end
          if (found_q || (!rv_q && !issue)) begin
            if (!found_q) begin
              idx_q <= '0; found_q <= 1'b0; state_q <= S_LRU1;
            end else begin
              pick_e_q <= '{pref: pf_q, dirty: 1'b1, valid: 1'b1,
                            stamp: frame_q, key: key_q};
              sv_q <= 1'b1; slot_q <= SlotW'(pick_q);
              if (CW'(pick_q) >= hw_q) hw_q <= CW'(pick_q) + 1'b1;
              state_q <= S_WRITE;
            end
          end
        end
        S_LRU1, S_LRU2, S_EVSCAN: begin
          if (rv_q) begin
            if (ra_q == '0 && state_q != S_LRU2) begin
              old_q <= rdata.stamp; pick_q <= '0; found_q <= rdata.pref;
            end else if (rdata.stamp < old_q &&
                         (state_q != S_LRU1 || !rdata.pref)) begin
              old_q <= rdata.stamp; pick_q <= ra_q; found_q <= rdata.pref;
            end
          end
          if (!rv_q && !issue && idx_q != '0) begin
            if (state_q == S_LRU1 && found_q) begin
              idx_q <= '0; state_q <= S_LRU2;
            end else if (state_q == S_EVSCAN) begin
              pick_e_q <= '0; evc_q <= evc_q + 1'b1;
              sv_q <= 1'b1; ev_q <= 1'b1; slot_q <= SlotW'(pick_q);
              if (CW'(pick_q) == hw_q - 1'b1) hw_q <= hw_q - 1'b1;
              state_q <= S_WRITE;
            end else begin
              pick_e_q <= '{pref: pf_q, dirty: 1'b1, valid: 1'b1,
                            stamp: frame_q, key: key_q};
              evc_q <= evc_q + 1'b1; ev_q <= 1'b1;
              sv_q <= 1'b1; slot_q <= SlotW'(pick_q);
              if (CW'(pick_q) >= hw_q) hw_q <= CW'(pick_q) + 1'b1;
              state_q <= S_WRITE;
            end
          end
        end
        S_DIRTY: if (!rv_q && !issue) state_q <= S_OUT;
        S_WRITE: state_q <= S_OUT;
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
